/* sv/wsfd_pkg.sv */
`default_nettype none

package wsfd_pkg;

    // Header bit fields and length codes.
    localparam logic [7:0] FIN_MASK     = 8'h80;
    localparam logic [7:0] MASK_BIT     = 8'h80;
    localparam logic [6:0] LEN_CODE_EXT = 7'd126;
    localparam logic [2:0] KEY_BYTES    = 3'd4;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

    // Parser phase, one-hot.
    typedef enum logic [5:0] {
        PH_HDR0 = 6'b000001,
        PH_HDR1 = 6'b000010,
        PH_EXT0 = 6'b000100,
        PH_EXT1 = 6'b001000,
        PH_MASK = 6'b010000,
        PH_DATA = 6'b100000
    } phase_t;

    // One registered stream byte handed to the parser.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic       valid;
        logic [7:0] data_out;
        logic       has_data;
        logic [3:0] frame_opcode;
        logic       frame_fin;
        logic       last_of_frame;
        logic       too_big;
    } result_t;

endpackage

`default_nettype wire

/* sv/wsfd_in_reg.sv */
`default_nettype none

module wsfd_in_reg
    import wsfd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       take,
    output in_item_t        item
);

    logic       valid_reg;
    logic [7:0] data_reg;

    // The register frees up when its byte is consumed in the same cycle.
    assign s_tready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            data_reg <= s_tdata;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

`default_nettype wire

/* sv/wsfd_parser.sv */
`default_nettype none

module wsfd_parser
    import wsfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] max_payload,
    input  wire in_item_t    item,
    output logic             take,
    input  wire logic        res_ready,
    output result_t          res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        fin_reg, fin_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [15:0] idx_reg, idx_next;

    result_t     res_reg;
    logic        emit;
    logic        emit_has, emit_last, emit_big;
    logic [7:0]  emit_data;
    logic [15:0] ext_len;
    logic [15:0] idx_inc;
    logic [7:0]  key_byte;
    logic        last_byte;

    // A byte is consumed whenever the result register can take a new value.
    assign take = item.valid && (!res_reg.valid || res_ready);

    assign ext_len   = {len_reg[15:8], item.data};
    assign idx_inc   = idx_reg + 16'd1;
    assign last_byte = ({1'b0, idx_reg} + 17'd1) >= {1'b0, len_reg};

    // Pick the key byte for this payload position; the first key byte sits on top.
    always_comb begin
        case (idx_reg[1:0])
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Next-state and result logic for one byte.
    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        emit        = 1'b0;
        emit_data   = 8'd0;
        emit_has    = 1'b0;
        emit_last   = 1'b0;
        emit_big    = 1'b0;
        unique case (phase_reg)
            PH_HDR1: begin
                if ((item.data & MASK_BIT) == 8'd0) begin
                    phase_next = PH_HDR0;
                end else if (item.data[6:0] == LEN_CODE_EXT) begin
                    phase_next = PH_EXT0;
                end else if (item.data[6:0] > LEN_CODE_EXT) begin
                    phase_next = PH_HDR0;
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_big   = 1'b1;
                end else begin
                    len_next   = {9'd0, item.data[6:0]};
                    idx_next   = 16'd0;
                    phase_next = PH_MASK;
                end
            end
            PH_EXT0: begin
                len_next   = {item.data, 8'd0};
                phase_next = PH_EXT1;
            end
            PH_EXT1: begin
                len_next = ext_len;
                if (ext_len > max_payload) begin
                    phase_next = PH_HDR0;
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    emit_big   = 1'b1;
                end else begin
                    idx_next   = 16'd0;
                    phase_next = PH_MASK;
                end
            end
            PH_MASK: begin
                key_next = {key_reg[23:0], item.data};
                idx_next = idx_inc;
                if (idx_inc >= {13'd0, KEY_BYTES}) begin
                    idx_next = 16'd0;
                    if (len_reg == 16'd0) begin
                        phase_next = PH_HDR0;
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                    end else begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                emit      = 1'b1;
                emit_data = item.data ^ key_byte;
                emit_has  = 1'b1;
                emit_last = last_byte;
                idx_next  = idx_inc;
                if (last_byte) begin
                    phase_next = PH_HDR0;
                end
            end
            default: begin
                // First header byte, and recovery from any stray phase code.
                opcode_next = item.data[3:0];
                fin_next    = (item.data & FIN_MASK) != 8'd0;
                phase_next  = PH_HDR1;
            end
        endcase
    end

    // Parser state advances on each consumed byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HDR0;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
            len_reg    <= 16'd0;
            key_reg    <= 32'd0;
            idx_reg    <= 16'd0;
        end else if (take) begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
        end
    end

    // Result register: valid bit under reset, payload loaded on a new result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else begin
            if (!res_reg.valid || res_ready) begin
                res_reg.valid <= take && emit;
            end
            if (take && emit) begin
                res_reg.data_out      <= emit_data;
                res_reg.has_data      <= emit_has;
                res_reg.frame_opcode  <= opcode_reg;
                res_reg.frame_fin     <= fin_reg;
                res_reg.last_of_frame <= emit_last;
                res_reg.too_big       <= emit_big;
            end
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

/* sv/websocket_frame_deframer_unit.sv */
// Path: an accepted byte is held in the input register, and its result is then
// loaded into the result register that drives the ports.
// Throughput: one byte per cycle, limited only by output back-pressure; bytes that
// produce no result (headers, lengths, key bytes) are consumed at that same rate.
// Reset: synchronous, active low on aresetn; clears the parser to wait for a first
// header byte, empties both registers and sets max_payload to 65535.
`default_nettype none

module websocket_frame_deframer_unit
    import wsfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: max_payload write.
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] data_out
    output logic             m_tlast,   // last_of_frame
    output logic [6:0]       m_tuser    // [0] has_data, [4:1] frame_opcode,
                                        // [5] frame_fin, [6] too_big
);

    logic [15:0] max_payload_reg;
    in_item_t    item;
    logic        take;
    result_t     res;

    // Maximum extended length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_we) begin
            max_payload_reg <= cfg_wdata;
        end
    end

    wsfd_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .take     (take),
        .item     (item)
    );

    wsfd_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .max_payload (max_payload_reg),
        .item        (item),
        .take        (take),
        .res_ready   (m_tready),
        .res         (res)
    );

    // Map the result onto the stream ports.
    assign m_tvalid = res.valid;
    assign m_tdata  = res.data_out;
    assign m_tlast  = res.last_of_frame;
    assign m_tuser  = {res.too_big, res.frame_fin, res.frame_opcode, res.has_data};

endmodule

`default_nettype wire

/* sv/wsfd_checker.sv */
`default_nettype none

module wsfd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic [6:0] m_tuser
);

    // A stalled result transaction keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Results without payload carry a zero data byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("data byte nonzero without payload");

    // Rejections and empty markers always close the frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("non-data result not marked last");

    // A rejected frame never carries payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[6] |-> !m_tuser[0])
        else $error("rejection carries payload");

    // Reset empties the result register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind websocket_frame_deframer_unit wsfd_checker u_wsfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* verif/websocket_frame_deframer_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the deframer, tracks the frame parser state on every
// accepted input transaction and compares each output transaction against the
// oldest outstanding prediction.
module websocket_frame_deframer_checker
    import wsfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [7:0]  m_tdata,
    input  wire logic        m_tlast,
    input  wire logic [6:0]  m_tuser,
    output int               mismatches,
    output int               results_due,
    output int               results_seen,
    output int               rejects_seen
);

    typedef struct packed {
        logic [7:0] data;
        logic       has_data;
        logic [3:0] opcode;
        logic       fin;
        logic       last;
        logic       too_big;
    } ws_result_t;

    // Shadow copy of the parser state and the length limit.
    phase_t      parse_phase;
    logic [3:0]  cur_opcode;
    logic        cur_fin;
    logic [15:0] frame_len;
    logic [15:0] byte_count;
    logic [31:0] mask_key;
    logic [15:0] max_payload;

    // Results predicted but not yet seen on the output stream.
    ws_result_t deframed_due[$];

    function automatic ws_result_t frame_result(logic [7:0] data, logic has, logic last,
                                                logic big);
        ws_result_t r;
        r.data     = data;
        r.has_data = has;
        r.opcode   = cur_opcode;
        r.fin      = cur_fin;
        r.last     = last;
        r.too_big  = big;
        return r;
    endfunction

    // Advance the parser by one stream byte and queue the result it causes, if any.
    task automatic deframe_byte(input logic [7:0] b);
        logic [6:0] code;
        int         key_shift;
        logic       is_last;
        code = b[6:0];
        case (parse_phase)
            PH_HDR1: begin
                if ((b & MASK_BIT) == 8'h00) begin
                    // Unmasked frames are dropped after their header.
                    parse_phase = PH_HDR0;
                end else if (code == LEN_CODE_EXT) begin
                    parse_phase = PH_EXT0;
                end else if (code > LEN_CODE_EXT) begin
                    deframed_due.push_back(frame_result(8'h00, 1'b0, 1'b1, 1'b1));
                    parse_phase = PH_HDR0;
                end else begin
                    frame_len   = {9'd0, code};
                    byte_count  = 16'd0;
                    parse_phase = PH_MASK;
                end
            end
            PH_EXT0: begin
                frame_len   = {b, 8'h00};
                parse_phase = PH_EXT1;
            end
            PH_EXT1: begin
                frame_len = {frame_len[15:8], b};
                if (frame_len > max_payload) begin
                    deframed_due.push_back(frame_result(8'h00, 1'b0, 1'b1, 1'b1));
                    parse_phase = PH_HDR0;
                end else begin
                    byte_count  = 16'd0;
                    parse_phase = PH_MASK;
                end
            end
            PH_MASK: begin
                mask_key   = {mask_key[23:0], b};
                byte_count = byte_count + 16'd1;
                if (byte_count >= KEY_BYTES) begin
                    byte_count = 16'd0;
                    if (frame_len == 16'd0) begin
                        // Empty frame: a single marker closes it.
                        deframed_due.push_back(frame_result(8'h00, 1'b0, 1'b1, 1'b0));
                        parse_phase = PH_HDR0;
                    end else begin
                        parse_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                key_shift = 24 - 8 * int'(byte_count[1:0]);
                is_last   = (int'(byte_count) + 1 >= int'(frame_len));
                deframed_due.push_back(frame_result(b ^ 8'(mask_key >> key_shift), 1'b1,
                                                    is_last, 1'b0));
                byte_count = byte_count + 16'd1;
                if (is_last) begin
                    parse_phase = PH_HDR0;
                end
            end
            default: begin
                cur_opcode  = b[3:0];
                cur_fin     = (b & FIN_MASK) != 8'h00;
                parse_phase = PH_HDR1;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input ws_result_t want,
                                   input ws_result_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s (expected/actual) data %02h/%02h has_data %0d/%0d",
                     $realtime, what, want.data, got.data, want.has_data, got.has_data);
            $display("    opcode %h/%h fin %0d/%0d last %0d/%0d too_big %0d/%0d",
                     want.opcode, got.opcode, want.fin, got.fin, want.last, got.last,
                     want.too_big, got.too_big);
        end
    endtask

    // Compare one output transaction with the oldest prediction.
    task automatic check_result();
        ws_result_t got;
        ws_result_t want;
        got.data     = m_tdata;
        got.has_data = m_tuser[0];
        got.opcode   = m_tuser[4:1];
        got.fin      = m_tuser[5];
        got.last     = m_tlast;
        got.too_big  = m_tuser[6];
        results_seen++;
        if (got.too_big) begin
            rejects_seen++;
        end
        if (deframed_due.size() == 0) begin
            report_mismatch("result with nothing expected", '0, got);
        end else begin
            want = deframed_due.pop_front();
            if (got.data !== want.data || got.has_data !== want.has_data ||
                got.opcode !== want.opcode || got.fin !== want.fin ||
                got.last !== want.last || got.too_big !== want.too_big) begin
                report_mismatch("result mismatch", want, got);
            end
        end
    endtask

    // Outputs are checked before the new input is parsed, since a result can never
    // leave in the same cycle as the byte that causes it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_phase = PH_HDR0;
            cur_opcode  = 4'd0;
            cur_fin     = 1'b0;
            frame_len   = 16'd0;
            byte_count  = 16'd0;
            mask_key    = 32'd0;
            max_payload = MAX_PAYLOAD_RESET;
            deframed_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                check_result();
            end
            if (cfg_we) begin
                max_payload = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                deframe_byte(s_tdata);
            end
        end
        results_due <= deframed_due.size();
    end

endmodule

/* verif/tb_websocket_frame_deframer_unit.sv */
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_unit;
    import wsfd_pkg::*;

    typedef enum logic [2:0] {
        FRAME_SHORT,
        FRAME_EMPTY,
        FRAME_EXTENDED,
        FRAME_UNMASKED,
        FRAME_LONG_CODE,
        FRAME_OVERSIZE
    } frame_kind_t;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int TARGET_BYTES   = 1400;
    localparam int PHASE_BYTES    = 180;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [6:0]  m_tuser;

    int mismatches;
    int results_due;
    int results_seen;
    int rejects_seen;

    logic [15:0] max_now = MAX_PAYLOAD_RESET;
    int          bytes_sent;
    int          frames_sent;
    int          limit_writes;
    int          burst_left;
    int          cycle_count;
    int          rx_mode;
    int          rx_left;
    int          rx_tick;

    always #10 aclk = ~aclk;

    websocket_frame_deframer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    websocket_frame_deframer_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .results_due  (results_due),
        .results_seen (results_seen),
        .rejects_seen (rejects_seen)
    );

    // Run guard.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, results_due);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result back-pressure: switches between always ready, random stalls and a
    // fixed one-in-three pattern.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 80);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                m_tready <= (rx_tick % 3 == 0);
            end
        endcase
    end

    // Drive one stream byte and hold it until the transaction completes. The
    // sender idles only between bursts, so back-to-back bursts keep tvalid high.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        burst_left--;
        bytes_sent++;
    endtask

    // Stop sending and let every outstanding result drain, then wait out any bytes
    // that are still in flight but cause no result.
    task automatic drain_stream();
        s_tvalid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (results_due != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_payload(input logic [15:0] value);
        drain_stream();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        max_now = value;
        limit_writes++;
    endtask

    // Send one frame of the given kind. For unmasked frames len supplies the low
    // seven bits of the second header byte; otherwise it is the declared payload length, unused by long-code frames.
    task automatic send_frame(input frame_kind_t kind, input logic [7:0] first,
                              input logic [15:0] len);
        send_byte(first);
        case (kind)
            FRAME_UNMASKED: begin
                send_byte({1'b0, len[6:0]});
            end
            FRAME_LONG_CODE: begin
                send_byte(MASK_BIT | 8'h7F);
            end
            FRAME_EXTENDED, FRAME_OVERSIZE: begin
                send_byte(MASK_BIT | {1'b0, LEN_CODE_EXT});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte(MASK_BIT | {1'b0, len[6:0]});
            end
        endcase
        if (kind == FRAME_SHORT || kind == FRAME_EMPTY || kind == FRAME_EXTENDED) begin
            repeat (4) send_byte(8'($urandom));
            repeat (len) send_byte(8'($urandom));
        end
        frames_sent++;
    endtask

    // Mostly well-formed masked frames with random content; the rest are frames
    // the block drops or rejects.
    task automatic send_random_frame();
        int          pick;
        int          cap;
        int          lo;
        frame_kind_t kind;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        len  = 16'd0;
        if (pick < 45) begin
            kind = FRAME_SHORT;
            if (pick == 0) begin
                len = 16'd125;
            end else if ($urandom_range(0, 9) == 0) begin
                len = 16'($urandom_range(13, 125));
            end else begin
                len = 16'($urandom_range(1, 12));
            end
        end else if (pick < 55) begin
            kind = FRAME_EMPTY;
        end else if (pick < 72) begin
            kind = FRAME_EXTENDED;
            cap  = (max_now < 16'd200) ? int'(max_now) : 200;
            len  = ($urandom_range(0, 3) == 0) ? 16'(cap) : 16'($urandom_range(0, cap));
        end else if (pick < 82) begin
            kind = FRAME_UNMASKED;
            len  = 16'($urandom);
        end else if (pick < 90 || max_now == 16'hFFFF) begin
            kind = FRAME_LONG_CODE;
        end else begin
            kind = FRAME_OVERSIZE;
            lo   = int'(max_now) + 1;
            case ($urandom_range(0, 2))
                0: len = 16'(lo);
                1: len = 16'hFFFF;
                default: len = 16'($urandom_range(lo, 65535));
            endcase
        end
        send_frame(kind, 8'($urandom), len);
    endtask

    initial begin
        int          phase_no;
        int          phase_start;
        logic [15:0] next_max;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames: all-ones header with length code 127, an all-zero
        // unmasked header, an empty frame, a one-byte frame, an extended length
        // frame, then an extended length over a zero limit.
        send_frame(FRAME_LONG_CODE, 8'hFF, 16'd0);
        send_frame(FRAME_UNMASKED, 8'h00, 16'd0);
        send_frame(FRAME_EMPTY, 8'h81, 16'd0);
        send_frame(FRAME_SHORT, 8'h02, 16'd1);
        send_frame(FRAME_EXTENDED, 8'h8A, 16'd1);
        write_max_payload(16'd0);
        send_frame(FRAME_OVERSIZE, 8'h09, 16'hFFFF);

        // Random frames in phases, each under its own length limit.
        phase_no = 0;
        while (bytes_sent < TARGET_BYTES) begin
            case (phase_no % 5)
                0: next_max = 16'hFFFF;
                1: next_max = 16'd0;
                2: next_max = 16'($urandom_range(1, 40));
                3: next_max = 16'($urandom_range(41, 400));
                default: next_max = 16'($urandom);
            endcase
            write_max_payload(next_max);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES && bytes_sent < TARGET_BYTES) begin
                send_random_frame();
            end
            phase_no++;
        end

        drain_stream();
        repeat (8) @(posedge aclk);

        $display("Sent %0d stream bytes in %0d frames under %0d length limit settings.",
                 bytes_sent, frames_sent, limit_writes);
        $display("Checked %0d results, %0d of them frame rejections; %0d mismatches.",
                 results_seen, rejects_seen, mismatches);
        if (mismatches == 0 && results_due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
